[design/cat_pkg.sv]
`default_nettype none
package cat_pkg;

    localparam int unsigned ONE_Q16   = 65536;
    localparam int unsigned THRESH_LO = 21823;
    localparam int unsigned THRESH_HI = ONE_Q16 - THRESH_LO;
    localparam logic [16:0] MTS_RESET = 17'd7;

    // ceil(2^46 / THRESH_LO): x * 2^16 / THRESH_LO == (x * W_RECIP) >> 30
    localparam logic [31:0] W_RECIP =
        32'(((64'd1 << 46) + 64'(THRESH_LO) - 64'd1) / 64'(THRESH_LO));

    typedef struct packed {
        logic signed [31:0] prev_value;
        logic signed [31:0] prev_key_time;
        logic signed [31:0] cur_value;
        logic signed [31:0] cur_key_time;
        logic signed [31:0] next_value;
        logic signed [31:0] next_key_time;
    } t_in;

    typedef struct packed {
        logic signed [31:0] tangent;
        logic               saturated;
    } t_out;

endpackage
`default_nettype wire

[design/cat_div.sv]
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// Accepts one operand pair per cycle; the quotient is registered at the last stage.
module cat_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33
) (
    input  wire logic             i_clk,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output      logic [NUM_W-1:0] o_quo
);
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_prev;
        logic [NUM_W-1:0] num_prev;
        logic [DEN_W-1:0] den_prev;
        logic [NUM_W-1:0] quo_prev;
        logic [DEN_W:0]   trial;
        logic             take;
        logic [DEN_W-1:0] n_rem;

        if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign num_prev = i_num;
            assign den_prev = i_den;
            assign quo_prev = '0;
        end else begin : g_next
            assign rem_prev = r_rem[k-1];
            assign num_prev = r_num[k-1];
            assign den_prev = r_den[k-1];
            assign quo_prev = r_quo[k-1];
        end

        assign trial = {rem_prev, num_prev[NUM_W-1]};
        assign take  = (trial >= {1'b0, den_prev});
        assign n_rem = take ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_num[k] <= {num_prev[NUM_W-2:0], 1'b0};
            r_den[k] <= den_prev;
            r_quo[k] <= {quo_prev[NUM_W-2:0], take};
        end
    end

    assign o_quo = r_quo[NUM_W-1];
endmodule
`default_nettype wire

[design/clamped_auto_tangent_unit.sv]
`default_nettype none
// Clamped automatic tangent of a Hermite curve key, Q16.16 in and out.
// Fully pipelined: a transaction may start in every cycle (o_busy is always
// low) and its result appears with o_valid once it has passed the 49-stage
// slope/fraction dividers, the one-stage blend weight reciprocal multiply
// and six arithmetic stages. The receiver cannot stall; results are shown
// for one cycle. min_time_step is written through the cfg channel (always
// ready) and should only change while idle.
module clamped_auto_tangent_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output      logic          o_busy,
    input  wire cat_pkg::t_in  i_in,
    output      logic          o_valid,
    output      cat_pkg::t_out o_out,
    input  wire logic          i_cfg_valid,
    output      logic          o_cfg_ready,
    input  wire logic [16:0]   i_cfg_data
);
    import cat_pkg::*;

    localparam int DIV_LAT = 49;
    localparam int W_LAT   = 1;

    typedef struct packed {
        logic same;
        logic rising;
        logic neg_pn;
        logic neg_pc;
        logic neg_cn;
    } t_side0;

    typedef struct packed {
        logic               same;
        logic               rising;
        logic               blend_en;
        logic signed [49:0] a;
        logic signed [49:0] b;
    } t_side1;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration register
    logic [16:0] r_mts;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mts <= MTS_RESET;
        end else if (i_cfg_valid) begin
            r_mts <= i_cfg_data;
        end
    end

    // ---------------- stage 0: gaps, differences, floors ----------------
    logic        [16:0] lo;
    logic signed [33:0] g_pn, g_pc, g_cn, lo_s;
    logic signed [32:0] dh_pn, dh_pc, dh_cn;
    logic               accept;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : v;
    endfunction

    function automatic logic [32:0] floor_gap(input logic signed [33:0] g,
                                              input logic signed [33:0] l);
        return (g < l) ? l[32:0] : g[32:0];
    endfunction

    assign accept = i_start & ~o_busy;
    assign lo     = (r_mts == '0) ? 17'd1 : r_mts;
    assign lo_s   = $signed({17'b0, lo});
    assign g_pn   = 34'(i_in.next_key_time) - 34'(i_in.prev_key_time);
    assign g_pc   = 34'(i_in.cur_key_time)  - 34'(i_in.prev_key_time);
    assign g_cn   = 34'(i_in.next_key_time) - 34'(i_in.cur_key_time);
    assign dh_pn  = 33'(i_in.next_value) - 33'(i_in.prev_value);
    assign dh_pc  = 33'(i_in.cur_value)  - 33'(i_in.prev_value);
    assign dh_cn  = 33'(i_in.next_value) - 33'(i_in.cur_value);

    logic        r0_valid;
    t_side0      r0_side;
    logic [32:0] r0_m_pn, r0_m_pc, r0_m_cn, r0_t_pn, r0_t_pc, r0_t_cn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_side.same   <= (dh_pc > 0 && dh_cn > 0) || (dh_pc < 0 && dh_cn < 0);
        r0_side.rising <= dh_pn > 0;
        r0_side.neg_pn <= dh_pn[32];
        r0_side.neg_pc <= dh_pc[32];
        r0_side.neg_cn <= dh_cn[32];
        r0_m_pn        <= mag33(dh_pn);
        r0_m_pc        <= mag33(dh_pc);
        r0_m_cn        <= mag33(dh_cn);
        r0_t_pn        <= floor_gap(g_pn, lo_s);
        r0_t_pc        <= floor_gap(g_pc, lo_s);
        r0_t_cn        <= floor_gap(g_cn, lo_s);
    end

    // ---------------- slope and height fraction dividers ----------------
    logic [48:0] q_pn, q_pc, q_cn, q_fr;

    cat_div #(.NUM_W(49), .DEN_W(33)) u_div_pn (
        .i_clk(i_clk), .i_num({r0_m_pn, 16'b0}), .i_den(r0_t_pn), .o_quo(q_pn));
    cat_div #(.NUM_W(49), .DEN_W(33)) u_div_pc (
        .i_clk(i_clk), .i_num({r0_m_pc, 16'b0}), .i_den(r0_t_pc), .o_quo(q_pc));
    cat_div #(.NUM_W(49), .DEN_W(33)) u_div_cn (
        .i_clk(i_clk), .i_num({r0_m_cn, 16'b0}), .i_den(r0_t_cn), .o_quo(q_cn));
    // fraction is garbage on a crest/flat (dh_pn may be zero); masked later
    cat_div #(.NUM_W(49), .DEN_W(33)) u_div_fr (
        .i_clk(i_clk), .i_num({r0_m_pc, 16'b0}), .i_den(r0_m_pn), .o_quo(q_fr));

    logic   r_v0 [DIV_LAT];
    t_side0 r_s0 [DIV_LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_v0[i] <= 1'b0;
        end else begin
            r_v0[0] <= r0_valid;
            for (int i = 1; i < DIV_LAT; i++) r_v0[i] <= r_v0[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        r_s0[0] <= r0_side;
        for (int i = 1; i < DIV_LAT; i++) r_s0[i] <= r_s0[i-1];
    end

    // ---------------- stage A: signed slopes, thresholds ----------------
    t_side0             sa;
    logic signed [49:0] s_pn, s_pc, s_cn;
    logic        [16:0] frac;
    logic               is_lo, is_hi;

    assign sa    = r_s0[DIV_LAT-1];
    assign s_pn  = sa.neg_pn ? -$signed({1'b0, q_pn}) : $signed({1'b0, q_pn});
    assign s_pc  = sa.neg_pc ? -$signed({1'b0, q_pc}) : $signed({1'b0, q_pc});
    assign s_cn  = sa.neg_cn ? -$signed({1'b0, q_cn}) : $signed({1'b0, q_cn});
    assign frac  = q_fr[16:0];
    assign is_lo = frac < 17'(THRESH_LO);
    assign is_hi = frac > 17'(THRESH_HI);

    logic        rA_valid;
    t_side1      rA_side;
    logic [14:0] rA_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_valid <= 1'b0;
        end else begin
            rA_valid <= r_v0[DIV_LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        rA_side.same     <= sa.same;
        rA_side.rising   <= sa.rising;
        rA_side.blend_en <= is_lo | is_hi;
        rA_side.a        <= s_pn;
        rA_side.b        <= is_lo ? s_pc : s_cn;
        rA_x             <= is_lo ? 15'(17'(THRESH_LO) - frac)
                                  : 15'(frac - 17'(THRESH_HI));
    end

    // ---------------- blend weight: x * 65536 / 21823 ----------------
    // reciprocal multiply, exact for every x up to the low threshold
    logic [46:0] w_prod;
    logic [16:0] r_w;

    assign w_prod = 47'(rA_x) * 47'(W_RECIP);

    always_ff @(posedge i_clk) begin
        r_w <= w_prod[46:30];
    end

    logic   r_v1 [W_LAT];
    t_side1 r_s1 [W_LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < W_LAT; i++) r_v1[i] <= 1'b0;
        end else begin
            r_v1[0] <= rA_valid;
            for (int i = 1; i < W_LAT; i++) r_v1[i] <= r_v1[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        r_s1[0] <= rA_side;
        for (int i = 1; i < W_LAT; i++) r_s1[i] <= r_s1[i-1];
    end

    // ---------------- stage B: difference magnitude ----------------
    t_side1             sb;
    logic        [16:0] w;
    logic signed [50:0] d;
    logic        [49:0] m;

    assign sb = r_s1[W_LAT-1];
    assign w  = r_w;
    assign d  = 51'(sb.b) - 51'(sb.a);
    assign m  = d[50] ? 50'(-d) : d[49:0];

    logic        rB_valid;
    t_side1      rB_side;
    logic        rB_full, rB_dneg;
    logic [16:0] rB_w;
    logic [33:0] rB_mhi;
    logic [15:0] rB_mlo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rB_valid <= 1'b0;
        end else begin
            rB_valid <= r_v1[W_LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        rB_side <= sb;
        rB_full <= w >= 17'(ONE_Q16);
        rB_dneg <= d[50];
        rB_w    <= w;
        rB_mhi  <= m[49:16];
        rB_mlo  <= m[15:0];
    end

    // ---------------- stage C: partial products ----------------
    logic        rC_valid;
    t_side1      rC_side;
    logic        rC_full, rC_dneg;
    logic [50:0] rC_p1;
    logic [32:0] rC_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rC_valid <= 1'b0;
        end else begin
            rC_valid <= rB_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        rC_side <= rB_side;
        rC_full <= rB_full;
        rC_dneg <= rB_dneg;
        rC_p1   <= 51'(rB_mhi) * 51'(rB_w);
        rC_p2   <= 33'(rB_mlo) * 33'(rB_w);
    end

    // ---------------- stage D: blend and clamp choice ----------------
    logic        [51:0] p;
    logic signed [51:0] a_x, c, res;
    logic               better;

    assign p   = 52'(rC_p1) + 52'(rC_p2[32:16]);
    assign a_x = 52'(rC_side.a);
    assign c   = rC_full ? 52'(rC_side.b)
               : (rC_dneg ? a_x - $signed(p) : a_x + $signed(p));
    assign better = rC_side.rising ? (c < a_x) : (c > a_x);

    always_comb begin
        res = a_x;
        if (rC_side.blend_en && better) begin
            res = c;
        end
        if (!rC_side.same) begin
            res = '0;
        end
    end

    logic               rD_valid;
    logic signed [51:0] rD_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rD_valid <= 1'b0;
        end else begin
            rD_valid <= rC_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        rD_res <= res;
    end

    // ---------------- output: saturate to Q16.16 ----------------
    logic r_valid;
    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= rD_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (rD_res > 52'sh7FFFFFFF) begin
            r_out.tangent   <= 32'sh7FFFFFFF;
            r_out.saturated <= 1'b1;
        end else if (rD_res < -52'sh80000000) begin
            r_out.tangent   <= 32'sh80000000;
            r_out.saturated <= 1'b1;
        end else begin
            r_out.tangent   <= rD_res[31:0];
            r_out.saturated <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r0_valid |-> ##(DIV_LAT + W_LAT + 5) o_valid)
        else $error("transaction lost in pipeline");

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.saturated) |->
        (o_out.tangent == 32'sh7FFFFFFF || o_out.tangent == 32'sh80000000))
        else $error("saturation flag without rail value");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rC_valid && !rC_side.same) |-> ##2 (o_out.tangent == 0 && !o_out.saturated))
        else $error("crest or flat did not give zero tangent");

endmodule
`default_nettype wire
